// ----- rtl/quoted_argument_tokenizer_macros.svh -----
// Assertion macros for the quoted argument tokenizer.
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off in reset
`define QAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qat assertion failed");

// next-cycle implication
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qat assertion failed");

`endif

// ----- rtl/qat_pkg.sv -----
// Package of the quoted argument tokenizer: types, codes and decode helpers.
package qat_pkg;

    typedef enum logic [3:0] {
        M_SPACE   = 4'd0,
        M_PARM    = 4'd1,
        M_SQUOTE  = 4'd2,
        M_DQUOTE  = 4'd3,
        M_BS      = 4'd4,
        M_HEX1    = 4'd5,
        M_HEXMORE = 4'd6,
        M_OCT2    = 4'd7,
        M_OCT3    = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        R_PARM   = 2'd0,
        R_SQUOTE = 2'd1,
        R_DQUOTE = 2'd2
    } t_ret;

    typedef enum logic [1:0] {
        K_BYTE   = 2'd0,
        K_END    = 2'd1,
        K_ACCEPT = 2'd2,
        K_REJECT = 2'd3
    } t_kind;

    localparam int MAX_RES = 4;

    localparam logic [1:0] REG_SEP_LOW  = 2'd0;
    localparam logic [1:0] REG_SEP_MID  = 2'd1;
    localparam logic [1:0] REG_SEP_HIGH = 2'd2;
    localparam logic [1:0] REG_SEP_TOP  = 2'd3;

    localparam logic [63:0] SEP_LOW_RST = 64'h0000_0001_0000_3E00;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef struct packed {
        t_mode      mode;
        t_ret       ret;
        logic [7:0] val;
        logic       failed;
    } t_pstate;

    typedef struct packed {
        logic [2:0]                 cnt;
        logic [MAX_RES-1:0][1:0]    res_kind;
        logic [MAX_RES-1:0][7:0]    res_byte;
    } t_bundle;

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h37;
    endfunction

    function automatic t_mode ret_to_mode(input t_ret r);
        t_mode m;
        unique case (r)
            R_SQUOTE: m = M_SQUOTE;
            R_DQUOTE: m = M_DQUOTE;
            default:  m = M_PARM;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/qat_if.sv -----
// Valid/ready channel interfaces for the input bytes and the result beats.
interface qat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface qat_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] token_byte;
    logic       last_of_run;

    modport source (output valid, output result_kind, output token_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input token_byte,
                    input last_of_run, output ready);
endinterface

// ----- rtl/qat_step.sv -----
// Per-byte parse step: next parser state and the result beats one byte causes.
module qat_step
    import qat_pkg::*;
(
    input  logic [255:0] i_sep,
    input  logic [7:0]   i_byte,
    input  logic         i_eos,
    input  t_pstate      i_state,
    output t_pstate      o_state,
    output t_bundle      o_bnd
);

    t_mode      mode;
    t_ret       ret;
    logic [7:0] val;
    logic       fl;
    logic [2:0] n;
    logic       used;
    logic       sep;
    logic [4:0] hv;
    logic       oct;

    always_comb begin
        mode = i_state.mode;
        ret  = i_state.ret;
        val  = i_state.val;
        fl   = i_state.failed;
        n    = 3'd0;
        used = 1'b0;
        sep  = i_sep[i_byte];
        hv   = hex_digit(i_byte);
        oct  = is_oct(i_byte);
        o_bnd = '0;

        if (!fl) begin
            if (mode == M_HEXMORE) begin
                if (hv[4]) begin
                    o_bnd.res_kind[n[1:0]] = K_BYTE;
                    o_bnd.res_byte[n[1:0]] = {val[3:0], hv[3:0]};
                    n    = n + 3'd1;
                    used = 1'b1;
                end else begin
                    o_bnd.res_kind[n[1:0]] = K_BYTE;
                    o_bnd.res_byte[n[1:0]] = val;
                    n = n + 3'd1;
                end
                mode = ret_to_mode(ret);
            end else if (mode == M_OCT2 || mode == M_OCT3) begin
                if (oct) begin
                    val  = {val[4:0], i_byte[2:0]};
                    used = 1'b1;
                    if (mode == M_OCT3) begin
                        o_bnd.res_kind[n[1:0]] = K_BYTE;
                        o_bnd.res_byte[n[1:0]] = val;
                        n    = n + 3'd1;
                        mode = ret_to_mode(ret);
                    end else begin
                        mode = M_OCT3;
                    end
                end else begin
                    o_bnd.res_kind[n[1:0]] = K_BYTE;
                    o_bnd.res_byte[n[1:0]] = val;
                    n    = n + 3'd1;
                    mode = ret_to_mode(ret);
                end
            end

            if (!used) begin
                case (mode)
                    M_PARM: begin
                        if (sep) begin
                            o_bnd.res_kind[n[1:0]] = K_END;
                            n    = n + 3'd1;
                            mode = M_SPACE;
                        end else if (i_byte == CH_SQUOTE) begin
                            mode = M_SQUOTE;
                        end else if (i_byte == CH_DQUOTE) begin
                            mode = M_DQUOTE;
                        end else if (i_byte == CH_BSLASH) begin
                            ret  = R_PARM;
                            mode = M_BS;
                        end else begin
                            o_bnd.res_kind[n[1:0]] = K_BYTE;
                            o_bnd.res_byte[n[1:0]] = i_byte;
                            n = n + 3'd1;
                        end
                    end
                    M_SQUOTE: begin
                        if (i_byte == CH_SQUOTE) begin
                            mode = M_PARM;
                        end else if (i_byte == CH_BSLASH) begin
                            ret  = R_SQUOTE;
                            mode = M_BS;
                        end else begin
                            o_bnd.res_kind[n[1:0]] = K_BYTE;
                            o_bnd.res_byte[n[1:0]] = i_byte;
                            n = n + 3'd1;
                        end
                    end
                    M_DQUOTE: begin
                        if (i_byte == CH_DQUOTE) begin
                            mode = M_PARM;
                        end else if (i_byte == CH_BSLASH) begin
                            ret  = R_DQUOTE;
                            mode = M_BS;
                        end else begin
                            o_bnd.res_kind[n[1:0]] = K_BYTE;
                            o_bnd.res_byte[n[1:0]] = i_byte;
                            n = n + 3'd1;
                        end
                    end
                    M_BS: begin
                        if (i_byte == CH_X) begin
                            val  = 8'd0;
                            mode = M_HEX1;
                        end else if (oct) begin
                            val  = {5'd0, i_byte[2:0]};
                            mode = M_OCT2;
                        end else begin
                            o_bnd.res_kind[n[1:0]] = K_BYTE;
                            unique case (i_byte)
                                CH_A:    o_bnd.res_byte[n[1:0]] = 8'h07;
                                CH_B:    o_bnd.res_byte[n[1:0]] = 8'h08;
                                CH_E:    o_bnd.res_byte[n[1:0]] = 8'h1B;
                                CH_F:    o_bnd.res_byte[n[1:0]] = 8'h0C;
                                CH_N:    o_bnd.res_byte[n[1:0]] = 8'h0A;
                                CH_R:    o_bnd.res_byte[n[1:0]] = 8'h0D;
                                CH_T:    o_bnd.res_byte[n[1:0]] = 8'h09;
                                CH_V:    o_bnd.res_byte[n[1:0]] = 8'h0B;
                                default: o_bnd.res_byte[n[1:0]] = i_byte;
                            endcase
                            n    = n + 3'd1;
                            mode = ret_to_mode(ret);
                        end
                    end
                    M_HEX1: begin
                        if (!hv[4]) begin
                            fl = 1'b1;
                        end else begin
                            val  = {4'd0, hv[3:0]};
                            mode = M_HEXMORE;
                        end
                    end
                    default: begin
                        if (!sep) begin
                            if (i_byte == CH_SQUOTE) begin
                                mode = M_SQUOTE;
                            end else if (i_byte == CH_DQUOTE) begin
                                mode = M_DQUOTE;
                            end else if (i_byte == CH_BSLASH) begin
                                ret  = R_PARM;
                                mode = M_BS;
                            end else begin
                                o_bnd.res_kind[n[1:0]] = K_BYTE;
                                o_bnd.res_byte[n[1:0]] = i_byte;
                                n    = n + 3'd1;
                                mode = M_PARM;
                            end
                        end
                    end
                endcase
            end
        end

        if (i_eos) begin
            if (fl) begin
                o_bnd.res_kind[n[1:0]] = K_REJECT;
                n = n + 3'd1;
            end else begin
                if (mode == M_HEXMORE || mode == M_OCT2 || mode == M_OCT3) begin
                    o_bnd.res_kind[n[1:0]] = K_BYTE;
                    o_bnd.res_byte[n[1:0]] = val;
                    n    = n + 3'd1;
                    mode = ret_to_mode(ret);
                end
                if (mode == M_PARM) begin
                    o_bnd.res_kind[n[1:0]] = K_END;
                    n = n + 3'd1;
                    o_bnd.res_kind[n[1:0]] = K_ACCEPT;
                    n = n + 3'd1;
                end else if (mode == M_SQUOTE || mode == M_DQUOTE ||
                             mode == M_BS || mode == M_HEX1) begin
                    o_bnd.res_kind[n[1:0]] = K_REJECT;
                    n = n + 3'd1;
                end else begin
                    o_bnd.res_kind[n[1:0]] = K_ACCEPT;
                    n = n + 3'd1;
                end
            end
            mode = M_SPACE;
            ret  = R_PARM;
            val  = 8'd0;
            fl   = 1'b0;
        end

        o_bnd.cnt      = n;
        o_state.mode   = mode;
        o_state.ret    = ret;
        o_state.val    = val;
        o_state.failed = fl;
    end

endmodule

// ----- rtl/quoted_argument_tokenizer.sv -----
// Top level of the quoted argument tokenizer: channels, registers, result buffering.
//
// Input channel i_in: one string byte per beat, end_of_string on the final byte.
// Output channel o_out: result beats (token byte, token end, accept, reject);
// last_of_run marks the final beat caused by one input byte. After a reject
// the consumer drops the tokens already delivered for that string.
// APB port: four 64-bit separator mask registers at byte addresses 0, 8, 16, 24,
// bit k of a register flags byte value 64*index+k. Write them only while idle.
// Each accepted byte is parsed in the cycle it is taken; its zero to four results
// go into a result buffer and leave through the output register one per cycle
// while the receiver takes them. A result moves from the result buffer to the
// output register, which holds it until the receiver takes it.
// Throughput: one byte per cycle while each byte causes at most one result and
// the receiver does not stall; a byte causing more results holds the buffer until
// each of them has moved to the single-beat output register.
// The next byte is taken while the output register still holds an untaken beat.
// Reset: parser between arguments, buffer and output empty, masks to defaults
// (space, tab, newline, vertical tab, form feed, carriage return).
// Receiver stall: the output register and buffer hold, then i_in.ready drops.
`include "quoted_argument_tokenizer_macros.svh"

module quoted_argument_tokenizer
    import qat_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    qat_in_if.sink       i_in,
    qat_out_if.source    o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [63:0] r_sep_low;
    logic [63:0] r_sep_mid;
    logic [63:0] r_sep_high;
    logic [63:0] r_sep_top;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    t_pstate     r_state;
    t_pstate     n_state;
    t_bundle     n_bnd;

    logic                      r_bnd_valid;
    logic [2:0]                r_bnd_cnt;
    logic [1:0]                r_bnd_idx;
    logic [MAX_RES-1:0][1:0]   r_bnd_kind;
    logic [MAX_RES-1:0][7:0]   r_bnd_byte;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        out_load;
    logic        move;
    logic        bnd_last;
    logic        in_ready;
    logic        in_acc;

    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        unique case (reg_idx)
            REG_SEP_LOW:  prdata = r_sep_low;
            REG_SEP_MID:  prdata = r_sep_mid;
            REG_SEP_HIGH: prdata = r_sep_high;
            default:      prdata = r_sep_top;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_low  <= SEP_LOW_RST;
            r_sep_mid  <= '0;
            r_sep_high <= '0;
            r_sep_top  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SEP_LOW:  r_sep_low  <= pwdata;
                REG_SEP_MID:  r_sep_mid  <= pwdata;
                REG_SEP_HIGH: r_sep_high <= pwdata;
                default:      r_sep_top  <= pwdata;
            endcase
        end
    end

    qat_step u_step (
        .i_sep   ({r_sep_top, r_sep_high, r_sep_mid, r_sep_low}),
        .i_byte  (i_in.in_byte),
        .i_eos   (i_in.end_of_string),
        .i_state (r_state),
        .o_state (n_state),
        .o_bnd   (n_bnd)
    );

    assign out_load = !r_out_valid || o_out.ready;
    assign move     = r_bnd_valid && out_load;
    assign bnd_last = {1'b0, r_bnd_idx} == (r_bnd_cnt - 3'd1);
    assign in_ready = !r_bnd_valid || (move && bnd_last);
    assign in_acc   = i_in.valid && in_ready;

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{mode: M_SPACE, ret: R_PARM, val: 8'd0, failed: 1'b0};
            r_bnd_valid <= 1'b0;
            r_bnd_idx   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state     <= n_state;
                r_bnd_valid <= n_bnd.cnt != 3'd0;
                r_bnd_idx   <= 2'd0;
            end else if (move && bnd_last) begin
                r_bnd_valid <= 1'b0;
            end else if (move) begin
                r_bnd_idx <= r_bnd_idx + 2'd1;
            end

            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bnd_cnt  <= n_bnd.cnt;
            r_bnd_kind <= n_bnd.res_kind;
            r_bnd_byte <= n_bnd.res_byte;
        end
        if (move) begin
            r_out_kind <= r_bnd_kind[r_bnd_idx];
            r_out_byte <= r_bnd_byte[r_bnd_idx];
            r_out_last <= bnd_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.token_byte  = r_out_byte;
    assign o_out.last_of_run = r_out_last;

    `QAT_ASSERT_NOW(a_bnd_idx_in_range, i_clk, i_rst_n, r_bnd_valid, (r_bnd_cnt != 3'd0) && ({1'b0, r_bnd_idx} < r_bnd_cnt))
    `QAT_ASSERT_NOW(a_accept_only_when_drained, i_clk, i_rst_n, in_acc && r_bnd_valid, move && bnd_last)
    `QAT_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last_of_run, r_out_valid)
    `QAT_ASSERT_NOW(a_failed_in_hex1, i_clk, i_rst_n, r_state.failed, r_state.mode == M_HEX1)

endmodule

// ----- bench/qat_checker.sv -----
`timescale 1ns / 1ps
// Checker that mirrors the separator masks, predicts tokenizer result beats and compares them.
module qat_checker
    import qat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    qat_in_if           i_bytes,
    qat_out_if          i_results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_token_beat;

    t_token_beat pending_beats[$];
    t_token_beat run_beats[$];

    logic [63:0] sep_mask [4];
    t_mode       mode_q;
    t_ret        resume_q;
    logic [7:0]  esc_val;
    logic        hex_failed;

    int mismatches = 0;
    int beats_checked = 0;
    int beats_waiting = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = beats_checked;
    assign o_pending    = beats_waiting;

    function automatic logic is_separator(input logic [7:0] b);
        return sep_mask[b[7:6]][b[5:0]];
    endfunction

    function automatic int hex_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    function automatic logic octal_digit(input logic [7:0] b);
        return b >= "0" && b <= "7";
    endfunction

    function automatic void add_beat(input t_kind k, input logic [7:0] b);
        t_token_beat beat;
        beat.kind = k;
        beat.data = b;
        beat.last = 1'b0;
        run_beats.push_back(beat);
    endfunction

    function automatic t_mode resume_mode();
        case (resume_q)
            R_SQUOTE: return M_SQUOTE;
            R_DQUOTE: return M_DQUOTE;
            default:  return M_PARM;
        endcase
    endfunction

    function automatic void close_escape(input logic [7:0] v);
        add_beat(K_BYTE, v);
        mode_q = resume_mode();
    endfunction

    function automatic void open_escape(input t_ret r);
        resume_q = r;
        mode_q   = M_BS;
    endfunction

    function automatic void clear_parse();
        mode_q     = M_SPACE;
        resume_q   = R_PARM;
        esc_val    = 8'h00;
        hex_failed = 1'b0;
    endfunction

    function automatic void parse_plain(input logic [7:0] b);
        int digit;
        case (mode_q)
            M_PARM: begin
                if (is_separator(b)) begin
                    add_beat(K_END, 8'h00);
                    mode_q = M_SPACE;
                end else if (b == CH_SQUOTE) begin
                    mode_q = M_SQUOTE;
                end else if (b == CH_DQUOTE) begin
                    mode_q = M_DQUOTE;
                end else if (b == CH_BSLASH) begin
                    open_escape(R_PARM);
                end else begin
                    add_beat(K_BYTE, b);
                end
            end
            M_SQUOTE: begin
                if (b == CH_SQUOTE) mode_q = M_PARM;
                else if (b == CH_BSLASH) open_escape(R_SQUOTE);
                else add_beat(K_BYTE, b);
            end
            M_DQUOTE: begin
                if (b == CH_DQUOTE) mode_q = M_PARM;
                else if (b == CH_BSLASH) open_escape(R_DQUOTE);
                else add_beat(K_BYTE, b);
            end
            M_BS: begin
                case (b)
                    CH_A: close_escape(8'h07);
                    CH_B: close_escape(8'h08);
                    CH_E: close_escape(8'h1B);
                    CH_F: close_escape(8'h0C);
                    CH_N: close_escape(8'h0A);
                    CH_R: close_escape(8'h0D);
                    CH_T: close_escape(8'h09);
                    CH_V: close_escape(8'h0B);
                    CH_X: begin
                        esc_val = 8'h00;
                        mode_q  = M_HEX1;
                    end
                    default: begin
                        if (octal_digit(b)) begin
                            esc_val = b - "0";
                            mode_q  = M_OCT2;
                        end else begin
                            close_escape(b);
                        end
                    end
                endcase
            end
            M_HEX1: begin
                digit = hex_value(b);
                if (digit < 0) begin
                    hex_failed = 1'b1;
                end else begin
                    esc_val = digit[7:0];
                    mode_q  = M_HEXMORE;
                end
            end
            default: begin
                if (!is_separator(b)) begin
                    if (b == CH_SQUOTE) mode_q = M_SQUOTE;
                    else if (b == CH_DQUOTE) mode_q = M_DQUOTE;
                    else if (b == CH_BSLASH) open_escape(R_PARM);
                    else begin
                        add_beat(K_BYTE, b);
                        mode_q = M_PARM;
                    end
                end
            end
        endcase
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eos);
        logic        used;
        int          digit;
        t_token_beat beat;
        run_beats.delete();
        used = 1'b0;
        if (!hex_failed) begin
            if (mode_q == M_HEXMORE) begin
                digit = hex_value(b);
                if (digit >= 0) begin
                    close_escape({esc_val[3:0], digit[3:0]});
                    used = 1'b1;
                end else begin
                    close_escape(esc_val);
                end
            end else if (mode_q == M_OCT2 || mode_q == M_OCT3) begin
                if (octal_digit(b)) begin
                    esc_val = {esc_val[4:0], b[2:0]};
                    if (mode_q == M_OCT3) close_escape(esc_val);
                    else mode_q = M_OCT3;
                    used = 1'b1;
                end else begin
                    close_escape(esc_val);
                end
            end
            if (!used) parse_plain(b);
        end
        if (eos) begin
            if (hex_failed) begin
                add_beat(K_REJECT, 8'h00);
            end else begin
                if (mode_q == M_HEXMORE || mode_q == M_OCT2 || mode_q == M_OCT3)
                    close_escape(esc_val);
                if (mode_q == M_PARM) begin
                    add_beat(K_END, 8'h00);
                    add_beat(K_ACCEPT, 8'h00);
                end else if (mode_q == M_SQUOTE || mode_q == M_DQUOTE ||
                             mode_q == M_BS || mode_q == M_HEX1) begin
                    add_beat(K_REJECT, 8'h00);
                end else begin
                    add_beat(K_ACCEPT, 8'h00);
                end
            end
            clear_parse();
        end
        for (int i = 0; i < run_beats.size(); i++) begin
            beat      = run_beats[i];
            beat.last = (i == run_beats.size() - 1);
            pending_beats.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_token_beat want;
        if (!i_rst_n) begin
            sep_mask[REG_SEP_LOW]  = SEP_LOW_RST;
            sep_mask[REG_SEP_MID]  = 64'h0;
            sep_mask[REG_SEP_HIGH] = 64'h0;
            sep_mask[REG_SEP_TOP]  = 64'h0;
            clear_parse();
            pending_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) sep_mask[paddr[4:3]] = pwdata;
            if (i_results.valid && i_results.ready) begin
                if (pending_beats.size() == 0) begin
                    $error("result beat with no prediction pending: result_kind %0d token_byte %h",
                           i_results.result_kind, i_results.token_byte);
                    mismatches++;
                end else begin
                    want = pending_beats.pop_front();
                    beats_checked++;
                    if (i_results.result_kind !== want.kind) begin
                        $error("result_kind mismatch: expected %0d, got %0d",
                               want.kind, i_results.result_kind);
                        mismatches++;
                    end
                    if (i_results.token_byte !== want.data) begin
                        $error("token_byte mismatch: expected %h, got %h",
                               want.data, i_results.token_byte);
                        mismatches++;
                    end
                    if (i_results.last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %0d, got %0d",
                               want.last, i_results.last_of_run);
                        mismatches++;
                    end
                end
            end
            if (i_bytes.valid && i_bytes.ready)
                tokenize_byte(i_bytes.in_byte, i_bytes.end_of_string);
        end
        beats_waiting = pending_beats.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Bench top for the tokenizer: clock, reset, string stimulus, receiver stalls and verdict.
module tb;
    import qat_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] ESCAPE_LETTERS [10] = '{CH_A, CH_B, CH_E, CH_F, CH_N, CH_R,
                                                   CH_T, CH_V, CH_BSLASH, CH_SQUOTE};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;

    qat_in_if  bytes_ch();
    qat_out_if results_ch();

    logic [63:0] mask_now [4];
    logic [7:0]  string_bytes[$];
    bit          idle_on;
    bit          hold_request;
    int          bytes_sent;
    int          strings_sent;
    int          settings_used;
    int          idle_cycles;
    int          quiet_cycles = 0;

    quoted_argument_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bytes_ch),
        .o_out   (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qat_checker token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bytes      (bytes_ch),
        .i_results    (results_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((bytes_ch.valid && bytes_ch.ready) || (results_ch.valid && results_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        results_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                results_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                results_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                results_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        @(negedge i_clk);
        bytes_ch.valid         <= 1'b1;
        bytes_ch.in_byte       <= b;
        bytes_ch.end_of_string <= eos;
        @(posedge i_clk);
        while (!bytes_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            bytes_ch.valid   <= 1'b0;
            bytes_ch.in_byte <= 8'($urandom_range(0, 255));
            repeat (gap - 1) @(negedge i_clk);
            idle_cycles += gap;
        end
    endtask

    task automatic send_string();
        for (int i = 0; i < string_bytes.size(); i++)
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
        strings_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        bytes_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        mask_now[index] = value;
    endtask

    task automatic set_masks(input logic [63:0] low, input logic [63:0] mid,
                             input logic [63:0] high, input logic [63:0] top);
        write_reg(REG_SEP_LOW, low);
        write_reg(REG_SEP_MID, mid);
        write_reg(REG_SEP_HIGH, high);
        write_reg(REG_SEP_TOP, top);
        settings_used++;
    endtask

    function automatic logic [7:0] pick_separator();
        logic [7:0] b;
        logic [7:0] start;
        start = 8'($urandom_range(0, 255));
        for (int k = 0; k < 256; k++) begin
            b = start + 8'(k);
            if (mask_now[b[7:6]][b[5:0]]) return b;
        end
        return 8'h20;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        repeat (16) begin
            if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
            else b = 8'($urandom_range(8'h61, 8'h7A));
            if (b != CH_SQUOTE && b != CH_DQUOTE && b != CH_BSLASH &&
                !mask_now[b[7:6]][b[5:0]])
                return b;
        end
        return 8'h6B;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 8'h30 + 8'(v);
        if (v < 16) return 8'h61 + 8'(v - 10);
        return 8'h41 + 8'(v - 16);
    endfunction

    task automatic add_escape();
        string_bytes.push_back(CH_BSLASH);
        case ($urandom_range(0, 3))
            0: string_bytes.push_back(ESCAPE_LETTERS[$urandom_range(0, 9)]);
            1: begin
                string_bytes.push_back(CH_X);
                if ($urandom_range(0, 7) == 0) string_bytes.push_back(8'h67);
                else repeat ($urandom_range(1, 2)) string_bytes.push_back(hex_char());
            end
            2: repeat ($urandom_range(1, 3))
                string_bytes.push_back(8'h30 + 8'($urandom_range(0, 7)));
            default: string_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic add_quoted(input logic [7:0] quote);
        string_bytes.push_back(quote);
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
                0: add_escape();
                1: string_bytes.push_back(pick_separator());
                default: string_bytes.push_back(plain_char());
            endcase
        end
        if ($urandom_range(0, 7) != 0) string_bytes.push_back(quote);
    endtask

    task automatic compose_string();
        string_bytes.delete();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 5)) string_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: repeat ($urandom_range(1, 4)) string_bytes.push_back(plain_char());
                    3: add_quoted(CH_SQUOTE);
                    4: add_quoted(CH_DQUOTE);
                    5, 6, 7: add_escape();
                    8: repeat ($urandom_range(1, 2)) string_bytes.push_back(pick_separator());
                    default: string_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    task automatic run_strings(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            compose_string();
            send_string();
        end
    endtask

    initial begin : stimulus
        bytes_ch.valid         = 1'b0;
        bytes_ch.in_byte       = 8'h00;
        bytes_ch.end_of_string = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 5'd0;
        pwdata   = 64'h0;
        i_rst_n  = 1'b0;
        idle_on  = 1'b1;
        hold_request = 1'b0;
        mask_now[REG_SEP_LOW]  = SEP_LOW_RST;
        mask_now[REG_SEP_MID]  = 64'h0;
        mask_now[REG_SEP_HIGH] = 64'h0;
        mask_now[REG_SEP_TOP]  = 64'h0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty quoted argument, then octal escape that wraps past 255
        string_bytes = '{CH_SQUOTE, CH_SQUOTE, 8'h20, CH_BSLASH, 8'h37, 8'h37, 8'h37};
        send_string();
        // zero and all-ones bytes, digit nine escaped, open double quote
        string_bytes = '{8'h00, 8'hFF, CH_BSLASH, 8'h39, CH_DQUOTE};
        send_string();
        // one-digit hex escape closed by a plain byte
        string_bytes = '{CH_BSLASH, CH_X, 8'h34, 8'h47};
        send_string();
        // bad hex digit, trailing bytes dropped
        string_bytes = '{CH_BSLASH, CH_X, 8'h5A, 8'h71};
        send_string();
        // named and unknown escapes, string ends inside an escape
        string_bytes = '{CH_BSLASH, CH_N, CH_BSLASH, 8'h71, CH_BSLASH};
        send_string();
        run_strings(30);

        drain();
        set_masks(64'h0, 64'h0, 64'h0, 64'h0);
        run_strings(20);

        drain();
        set_masks('1, '1, '1, '1);
        run_strings(20);

        drain();
        set_masks(SEP_LOW_RST | (64'd1 << 44),
                  {$urandom, $urandom} & {$urandom, $urandom},
                  {$urandom, $urandom} & {$urandom, $urandom},
                  {$urandom, $urandom} & {$urandom, $urandom});
        hold_request = 1'b1;
        run_strings(30);

        drain();
        idle_on = 1'b0;
        set_masks(SEP_LOW_RST, 64'h0, 64'h0, 64'h0);
        run_strings(30);
        drain();

        $display("Sent %0d bytes in %0d strings under %0d separator settings, %0d idle cycles",
                 bytes_sent, strings_sent, settings_used, idle_cycles);
        $display("Compared %0d result beats, including a long receiver hold-off", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
